// File: hdl/fss_pkg.sv
// ----------------------------------------------------------------------------
// fss_pkg
// Shared types, register indexes and scoring constants for the fuzzy
// subsequence scorer.
// ----------------------------------------------------------------------------
`default_nettype none

package fss_pkg;

	// Default sizes, used as defaults by the top level parameters
	localparam int MAX_PATTERN_DEF = 32;
	localparam int MAX_TEXT_DEF    = 256;

	// Configuration port
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 64;
	localparam int LEN_REG_W   = 6;
	localparam int CHARS_PER_REG = 8;

	localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LENGTH = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_CHARS_0_7      = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_CHARS_8_15     = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_CHARS_16_23    = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_CHARS_24_31    = 3'd4;

	// Scoring
	localparam int SCORE_W     = 12;
	localparam int SUBSEQ_W    = 11;
	localparam logic [SCORE_W-1:0]  SCORE_EMPTY        = 12'd1000;
	localparam logic [SCORE_W-1:0]  SCORE_SUBSTR_BASE  = 12'd3000;
	localparam logic [SUBSEQ_W-1:0] BONUS_MATCH        = 11'd10;
	localparam logic [SUBSEQ_W-1:0] BONUS_BOUNDARY     = 11'd10;
	localparam logic [SUBSEQ_W-1:0] BONUS_CONSECUTIVE  = 11'd15;

	localparam logic [7:0] CH_SLASH      = 8'h2F;
	localparam logic [7:0] CH_BACKSLASH  = 8'h5C;
	localparam logic [7:0] CH_DOT        = 8'h2E;
	localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
	localparam logic [7:0] CH_DASH       = 8'h2D;

	typedef struct packed {
		logic [7:0] text_char;
		logic       end_of_text;
	} in_word_t;

	typedef struct packed {
		logic [SCORE_W-1:0] score;
		logic               text_too_long;
	} out_word_t;

	// One step handed from the input stage to the scoring core
	typedef struct packed {
		logic     step;
		in_word_t word;
	} step_t;

	function automatic logic is_separator(input logic [7:0] c);
		return (c == CH_SLASH) || (c == CH_BACKSLASH) || (c == CH_DOT) ||
			(c == CH_UNDERSCORE) || (c == CH_DASH);
	endfunction

endpackage

`default_nettype wire

// File: hdl/fss_cfg_regs.sv
// ----------------------------------------------------------------------------
// fss_cfg_regs
// Pattern length and pattern character registers; gives the clamped
// active length.
// ----------------------------------------------------------------------------
`default_nettype none

module fss_cfg_regs #(
	parameter int MAX_PATTERN = fss_pkg::MAX_PATTERN_DEF,
	parameter int LEN_W       = $clog2(MAX_PATTERN + 1)
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_write,
	input  wire logic [fss_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  wire logic [fss_pkg::CFG_DATA_W-1:0]   cfg_data,
	output logic [MAX_PATTERN-1:0][7:0]           pattern,
	output logic [LEN_W-1:0]                      active_len
);

	logic [fss_pkg::LEN_REG_W-1:0] length_q;
	logic [MAX_PATTERN-1:0][7:0]   pattern_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			length_q  <= '0;
			pattern_q <= '0;
		end else if (cfg_write) begin
			if (cfg_index == fss_pkg::REG_PATTERN_LENGTH) begin
				length_q <= cfg_data[fss_pkg::LEN_REG_W-1:0];
			end
			for (int j = 0; j < MAX_PATTERN; j++) begin
				// character j sits in register 1 + j/8, byte j%8
				if ((cfg_index == fss_pkg::REG_CHARS_0_7   && j / 8 == 0) ||
					(cfg_index == fss_pkg::REG_CHARS_8_15  && j / 8 == 1) ||
					(cfg_index == fss_pkg::REG_CHARS_16_23 && j / 8 == 2) ||
					(cfg_index == fss_pkg::REG_CHARS_24_31 && j / 8 == 3)) begin
					pattern_q[j] <= cfg_data[(j % fss_pkg::CHARS_PER_REG) * 8 +: 8];
				end
			end
		end
	end

	assign pattern = pattern_q;

	// lengths beyond the pattern store count as a full pattern
	always_comb begin
		if (7'(length_q) > 7'(MAX_PATTERN)) begin
			active_len = LEN_W'(MAX_PATTERN);
		end else begin
			active_len = LEN_W'(length_q);
		end
	end

endmodule

`default_nettype wire

// File: hdl/fss_core.sv
// ----------------------------------------------------------------------------
// fss_core
// Per-text scoring state: shift-and substring search and greedy
// subsequence score, updated once per character; gives the final score.
// ----------------------------------------------------------------------------
`default_nettype none

module fss_core #(
	parameter int MAX_PATTERN = fss_pkg::MAX_PATTERN_DEF,
	parameter int MAX_TEXT    = fss_pkg::MAX_TEXT_DEF,
	parameter int LEN_W       = $clog2(MAX_PATTERN + 1),
	parameter int POS_W       = $clog2(MAX_TEXT + 1)
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire fss_pkg::step_t              step_in,
	input  wire logic [MAX_PATTERN-1:0][7:0] pattern,
	input  wire logic [LEN_W-1:0]            active_len,
	output fss_pkg::out_word_t               result
);

	logic [POS_W-1:0]                 pos_q, pos_d;
	logic [LEN_W-1:0]                 prog_q, prog_d;
	logic [fss_pkg::SUBSEQ_W-1:0]     subseq_q, subseq_d;
	logic                             prev_hit_q, prev_hit_d;
	logic [7:0]                       prev_char_q, prev_char_d;
	logic [MAX_PATTERN-1:0]           vec_q, vec_d;
	logic                             found_q, found_d;
	logic [POS_W-1:0]                 start_q, start_d;
	logic                             ovf_q, ovf_d;

	logic [MAX_PATTERN-1:0]           match_mask;
	logic [MAX_PATTERN-1:0]           top_sel;
	logic [MAX_PATTERN-1:0]           vec_new;
	logic [7:0]                       prog_char;
	logic                             prog_hit;
	logic                             in_range;
	logic [7:0]                       ch;
	logic [fss_pkg::SCORE_W-1:0]      start_wide;
	logic [fss_pkg::SUBSEQ_W-1:0]     gain;

	assign ch = step_in.word.text_char;

	always_comb begin
		match_mask = '0;
		top_sel    = '0;
		prog_char  = '0;
		for (int j = 0; j < MAX_PATTERN; j++) begin
			match_mask[j] = (LEN_W'(j) < active_len) && (pattern[j] == ch);
			top_sel[j]    = (LEN_W'(j + 1) == active_len);
			if (LEN_W'(j) == prog_q) begin
				prog_char = pattern[j];
			end
		end
	end

	assign vec_new    = ((vec_q << 1) | MAX_PATTERN'(1)) & match_mask;
	assign prog_hit   = (prog_q < active_len) && (ch == prog_char);
	assign in_range   = (pos_q < POS_W'(MAX_TEXT));
	assign start_wide = fss_pkg::SCORE_W'(pos_q) + fss_pkg::SCORE_W'(1)
		- fss_pkg::SCORE_W'(active_len);

	always_comb begin
		gain = fss_pkg::BONUS_MATCH;
		if (prev_hit_q) begin
			gain = gain + fss_pkg::BONUS_CONSECUTIVE;
		end
		if (pos_q == '0 || fss_pkg::is_separator(prev_char_q)) begin
			gain = gain + fss_pkg::BONUS_BOUNDARY;
		end
	end

	always_comb begin
		pos_d       = pos_q;
		prog_d      = prog_q;
		subseq_d    = subseq_q;
		prev_hit_d  = prev_hit_q;
		prev_char_d = prev_char_q;
		vec_d       = vec_q;
		found_d     = found_q;
		start_d     = start_q;
		ovf_d       = ovf_q;
		if (in_range) begin
			if (active_len != '0) begin
				vec_d = vec_new;
				if (!found_q && |(vec_new & top_sel)) begin
					found_d = 1'b1;
					start_d = POS_W'(start_wide);
				end
				if (prog_hit) begin
					subseq_d   = subseq_q + gain;
					prog_d     = prog_q + LEN_W'(1);
					prev_hit_d = 1'b1;
				end else begin
					prev_hit_d = 1'b0;
				end
			end
			prev_char_d = ch;
			pos_d       = pos_q + POS_W'(1);
		end else begin
			ovf_d = 1'b1;
		end
	end

	// score from the state after this character
	always_comb begin
		result.text_too_long = ovf_d;
		if (active_len == '0) begin
			result.score = fss_pkg::SCORE_EMPTY;
		end else if (found_d) begin
			result.score = fss_pkg::SCORE_SUBSTR_BASE - fss_pkg::SCORE_W'(start_d);
		end else if (prog_d == active_len) begin
			result.score = fss_pkg::SCORE_W'(subseq_d);
		end else begin
			result.score = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			prog_q      <= '0;
			subseq_q    <= '0;
			prev_hit_q  <= 1'b1;
			prev_char_q <= '0;
			vec_q       <= '0;
			found_q     <= 1'b0;
			start_q     <= '0;
			ovf_q       <= 1'b0;
		end else if (step_in.step) begin
			if (step_in.word.end_of_text) begin
				pos_q       <= '0;
				prog_q      <= '0;
				subseq_q    <= '0;
				prev_hit_q  <= 1'b1;
				prev_char_q <= '0;
				vec_q       <= '0;
				found_q     <= 1'b0;
				start_q     <= '0;
				ovf_q       <= 1'b0;
			end else begin
				pos_q       <= pos_d;
				prog_q      <= prog_d;
				subseq_q    <= subseq_d;
				prev_hit_q  <= prev_hit_d;
				prev_char_q <= prev_char_d;
				vec_q       <= vec_d;
				found_q     <= found_d;
				start_q     <= start_d;
				ovf_q       <= ovf_d;
			end
		end
	end

endmodule

`default_nettype wire

// File: hdl/fuzzy_subsequence_scorer.sv
// ----------------------------------------------------------------------------
// fuzzy_subsequence_scorer
// Streams text characters against a configured pattern and gives one
// fuzzy match score per text.
// ----------------------------------------------------------------------------
// Takes one text character per cycle while the input is not stalled;
// characters pass the input register into the scoring state, and the
// last one's result loads the result register. The rate is set by the
// single per-text state update (shift-and vector, subsequence counters),
// combinational from the input to the result register. Only the last
// character of a text (end_of_text = 1) yields an output word; the input
// stalls only when such a word must load while a previous result is still
// waiting downstream. Score: 1000 for an empty pattern; 3000 minus the
// earliest start if the pattern is a substring; otherwise the greedy
// subsequence score (10 per match, +10 at the start or after / \ . _ -,
// +15 after a matched character, counting the first position as matched),
// or 0 if the pattern is not a subsequence. Characters past MAX_TEXT are
// ignored and text_too_long is set. Write the pattern registers only
// while no text is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module fuzzy_subsequence_scorer #(
	parameter int MAX_PATTERN = fss_pkg::MAX_PATTERN_DEF,
	parameter int MAX_TEXT    = fss_pkg::MAX_TEXT_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// configuration
	input  wire logic                            cfg_write,
	input  wire logic [fss_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [fss_pkg::CFG_DATA_W-1:0]  cfg_data,
	// text characters
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire fss_pkg::in_word_t               in_word,
	// scores
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output fss_pkg::out_word_t                   out_word
);

	localparam int LEN_W = $clog2(MAX_PATTERN + 1);
	localparam int POS_W = $clog2(MAX_TEXT + 1);

	logic [MAX_PATTERN-1:0][7:0] pattern;
	logic [LEN_W-1:0]            active_len;

	// input register
	logic                        valid_s1;
	fss_pkg::in_word_t           word_s1;
	// result register
	logic                        out_valid_q;
	fss_pkg::out_word_t          out_word_q;

	logic                        advance;
	fss_pkg::step_t              step;
	fss_pkg::out_word_t          result;

	fss_cfg_regs #(
		.MAX_PATTERN (MAX_PATTERN),
		.LEN_W       (LEN_W)
	) u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_write  (cfg_write),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.pattern    (pattern),
		.active_len (active_len)
	);

	// A held word moves on unless it is a last character and the result
	// slot is full and stalled.
	assign advance  = valid_s1 &&
		(!word_s1.end_of_text || !out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;

	assign step.step = advance;
	assign step.word = word_s1;

	fss_core #(
		.MAX_PATTERN (MAX_PATTERN),
		.MAX_TEXT    (MAX_TEXT),
		.LEN_W       (LEN_W),
		.POS_W       (POS_W)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.step_in    (step),
		.pattern    (pattern),
		.active_len (active_len),
		.result     (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			word_s1 <= in_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && word_s1.end_of_text) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && word_s1.end_of_text) begin
			out_word_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

endmodule

`default_nettype wire

// File: hdl/fss_checker.sv
// ----------------------------------------------------------------------------
// fss_checker
// Port-level checks for the fuzzy subsequence scorer, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module fss_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_valid,
	input wire logic               in_stall,
	input wire fss_pkg::in_word_t  in_word,
	input wire logic               out_valid,
	input wire logic               out_stall,
	input wire fss_pkg::out_word_t out_word
);

	// stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_word))
		else $error("result word changed while stalled");

	// input only backs up behind a stalled, full result slot
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a waiting result");

	// a fresh result must trace back to an accepted last character
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall && in_word.end_of_text, 2))
		else $error("result without a last character");

	// score never above the substring base
	a_score_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_word.score <= fss_pkg::SCORE_SUBSTR_BASE)
		else $error("score out of range");

endmodule

bind fuzzy_subsequence_scorer fss_checker u_fss_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.in_word   (in_word),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_word  (out_word)
);

`default_nettype wire
